[rtl/core/etq_pkg.sv]
// Package for the Euler to quaternion block: item types, CORDIC constants
// and the fixed-point helper functions. No dependencies.
`timescale 1ns / 1ps
package etq_pkg;

   localparam int CordicIters = 28;
   localparam logic signed [33:0] QPi     = 34'sd3373259426;
   localparam logic signed [33:0] QHalfPi = 34'sd1686629713;
   localparam logic signed [31:0] QGain   = 32'sd652032874;
   localparam logic signed [17:0] OutLimit = 18'sd16384;

   localparam logic signed [31:0] ATAN_TABLE [CordicIters] = '{
      32'sd843314857, 32'sd497837830, 32'sd263043837, 32'sd133525159,
      32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
      32'sd4194283,   32'sd2097151,   32'sd1048576,   32'sd524288,
      32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
      32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
      32'sd1024,      32'sd512,       32'sd256,       32'sd128,
      32'sd64,        32'sd32,        32'sd16,        32'sd8
   };

   typedef struct packed {
      logic signed [15:0] yaw_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] roll_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } rsp_type;

   // reduced half angle in 2^30 units, plus sign flip for sin/cos
   typedef struct packed {
      logic signed [31:0] z;
      logic               neg;
   } half_type;

   typedef struct packed {
      half_type yaw;
      half_type pitch;
      half_type roll;
   } work_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } cordic_type;

   function automatic half_type reduce_angle(logic signed [15:0] ang);
      logic signed [33:0] z;
      half_type           h;
      z = {{1{ang[15]}}, ang, 17'b0};
      h.neg = 1'b0;
      if (z > QHalfPi) begin
         z = z - QPi;
         h.neg = 1'b1;
      end else if (z < -QHalfPi) begin
         z = z + QPi;
         h.neg = 1'b1;
      end
      h.z = z[31:0];
      return h;
   endfunction

   function automatic cordic_type cordic_step(cordic_type c, logic [4:0] idx);
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      cordic_type         r;
      dx = c.y >>> idx;
      dy = c.x >>> idx;
      if (!c.z[31]) begin
         r.x = c.x - dx;
         r.y = c.y + dy;
         r.z = c.z - ATAN_TABLE[idx];
      end else begin
         r.x = c.x + dx;
         r.y = c.y - dy;
         r.z = c.z + ATAN_TABLE[idx];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] round_q30(logic signed [63:0] p);
      logic signed [63:0] s;
      s = p + 64'sd536870912;
      return s[61:30];
   endfunction

   function automatic logic signed [15:0] to_out(logic signed [63:0] q);
      logic signed [63:0] s;
      logic signed [17:0] r;
      s = q + 64'sd35184372088832;
      r = s[63:46];
      if (r > OutLimit) r = OutLimit;
      if (r < -OutLimit) r = -OutLimit;
      return r[15:0];
   endfunction

endpackage

[rtl/core/euler_to_quaternion.sv]
// Euler angles (ZYX) to unit quaternion, top level.
// Path: front register, queue, 29 CORDIC registers, three product/output
// stages. Throughput: one item per cycle while results are taken, set by
// the fully pipelined CORDIC; a held result stalls the pipeline.
// Reset: synchronous, clears all valid flags and the queue; no clearing pass.
// Depends on etq_pkg, etq_front, etq_queue, etq_back.
`timescale 1ns / 1ps
module euler_to_quaternion import etq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   logic     push_valid, push_ready, pop_valid, pop_ready;
   work_type push_data, pop_data;

   etq_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .push_valid, .push_ready, .push_data
   );

   etq_queue u_queue (
      .clock, .reset, .push_valid, .push_ready, .push_data,
      .pop_valid, .pop_ready, .pop_data
   );

   etq_back u_back (
      .clock, .reset, .pop_valid, .pop_ready, .pop_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule

[rtl/core/etq_front.sv]
// Front end: accepts angle items, halves and range-reduces each angle.
// Depends on etq_pkg.
`timescale 1ns / 1ps
module etq_front import etq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     push_valid,
   input  logic     push_ready,
   output work_type push_data
);
   logic     valid_ff, valid_in;
   work_type data_ff, data_in;

   assign req_ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_ready) begin
         valid_in      = req_valid;
         data_in.yaw   = reduce_angle(req_data.yaw_angle);
         data_in.pitch = reduce_angle(req_data.pitch_angle);
         data_in.roll  = reduce_angle(req_data.roll_angle);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      data_ff <= data_in;
   end
endmodule

[rtl/core/etq_queue.sv]
// Two-entry queue between front and back end.
// Depends on etq_pkg.
`timescale 1ns / 1ps
module etq_queue import etq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  work_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output work_type pop_data
);
   work_type   mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_data   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in    = push ? !wr_ff : wr_ff;
      rd_in    = pop ? !rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule

[rtl/core/etq_back.sv]
// Back end: 28-stage CORDIC for the three half angles, product stages
// and output rounding into the result register. Depends on etq_pkg.
`timescale 1ns / 1ps
module etq_back import etq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  work_type pop_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);
   localparam int NStg = CordicIters + 1;

   logic       adv;
   logic       cv_ff [NStg];
   cordic_type cs_ff [NStg][3];
   logic       cn_ff [NStg][3];

   logic               m1_v_ff;
   logic signed [31:0] cpcy_ff, spsy_ff, cpsy_ff, spcy_ff, cr_ff, sr_ff;
   logic               m2_v_ff;
   logic signed [63:0] p_ff [8];
   logic               out_v_ff;
   rsp_type            out_ff;

   half_type           h0 [3];
   logic signed [31:0] cosv [3];
   logic signed [31:0] sinv [3];

   // whole pipeline moves together; stalls only when the result is held
   assign adv       = !out_v_ff || rsp_ready;
   assign pop_ready = adv;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   assign h0[0] = pop_data.yaw;
   assign h0[1] = pop_data.pitch;
   assign h0[2] = pop_data.roll;

   always_ff @(posedge clock) begin
      if (reset) cv_ff[0] <= 1'b0;
      else if (adv) cv_ff[0] <= pop_valid;
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            cs_ff[0][a].x <= QGain;
            cs_ff[0][a].y <= 32'sd0;
            cs_ff[0][a].z <= h0[a].z;
            cn_ff[0][a]   <= h0[a].neg;
         end
      end
   end

   for (genvar i = 0; i < CordicIters; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (reset) cv_ff[i+1] <= 1'b0;
         else if (adv) cv_ff[i+1] <= cv_ff[i];
         if (adv) begin
            for (int a = 0; a < 3; a++) begin
               cs_ff[i+1][a] <= cordic_step(cs_ff[i][a], 5'(i));
               cn_ff[i+1][a] <= cn_ff[i][a];
            end
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         cosv[a] = cn_ff[NStg-1][a] ? -cs_ff[NStg-1][a].x : cs_ff[NStg-1][a].x;
         sinv[a] = cn_ff[NStg-1][a] ? -cs_ff[NStg-1][a].y : cs_ff[NStg-1][a].y;
      end
   end

   // index 0 yaw, 1 pitch, 2 roll
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff  <= 1'b0;
         m2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         m1_v_ff  <= cv_ff[NStg-1];
         m2_v_ff  <= m1_v_ff;
         out_v_ff <= m2_v_ff;
      end
      if (adv) begin
         cpcy_ff <= round_q30(64'(cosv[1]) * 64'(cosv[0]));
         spsy_ff <= round_q30(64'(sinv[1]) * 64'(sinv[0]));
         cpsy_ff <= round_q30(64'(cosv[1]) * 64'(sinv[0]));
         spcy_ff <= round_q30(64'(sinv[1]) * 64'(cosv[0]));
         cr_ff   <= cosv[2];
         sr_ff   <= sinv[2];
         p_ff[0] <= 64'(cr_ff) * 64'(cpcy_ff);
         p_ff[1] <= 64'(sr_ff) * 64'(spsy_ff);
         p_ff[2] <= 64'(sr_ff) * 64'(cpcy_ff);
         p_ff[3] <= 64'(cr_ff) * 64'(spsy_ff);
         p_ff[4] <= 64'(cr_ff) * 64'(spcy_ff);
         p_ff[5] <= 64'(sr_ff) * 64'(cpsy_ff);
         p_ff[6] <= 64'(cr_ff) * 64'(cpsy_ff);
         p_ff[7] <= 64'(sr_ff) * 64'(spcy_ff);
         out_ff.quat_w <= to_out(p_ff[0] + p_ff[1]);
         out_ff.quat_x <= to_out(p_ff[2] - p_ff[3]);
         out_ff.quat_y <= to_out(p_ff[4] + p_ff[5]);
         out_ff.quat_z <= to_out(p_ff[6] - p_ff[7]);
      end
   end
endmodule

[dv/euler_to_quaternion_tb.sv]
// Testbench for euler_to_quaternion: drives Euler angle items, predicts the
// quaternion with a local fixed-point CORDIC model, checks every result in order.
// Depends on etq_pkg and the euler_to_quaternion RTL.
`timescale 1ns / 1ps
module euler_to_quaternion_tb;
   import etq_pkg::*;

   localparam int Latency = 34;
   localparam longint CycleLimit = 400000;
   localparam longint AngPi = 64'sd3373259426;
   localparam longint AngHalfPi = 64'sd1686629713;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type quat_queue[$];
   int      fail_count = 0;
   longint  cycle_count = 0;
   bit      hold_off = 1'b0;
   bit      rx_random = 1'b1;

   longint atan_tab[28] = '{
      843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097151, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8};

   euler_to_quaternion dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // half-angle cos/sin in Q2.30
   function automatic void half_trig(input logic signed [15:0] ang, output longint c,
                                     output longint s);
      longint z, x, y, dx, dy;
      bit     flip;
      z = longint'(ang) * 131072;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (z > AngHalfPi) begin
         z -= AngPi;
         flip = 1'b1;
      end else if (z < -AngHalfPi) begin
         z += AngPi;
         flip = 1'b1;
      end
      for (int i = 0; i < 28; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint round_prod(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic logic signed [15:0] quat_round(longint q);
      longint r;
      r = (q + (64'sd1 <<< 45)) >>> 46;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   function automatic rsp_type predict_quat(req_type a);
      longint cy, sy, cp, sp, cr, sr, cpcy, spsy, cpsy, spcy;
      rsp_type q;
      half_trig(a.yaw_angle, cy, sy);
      half_trig(a.pitch_angle, cp, sp);
      half_trig(a.roll_angle, cr, sr);
      cpcy = round_prod(cp, cy);
      spsy = round_prod(sp, sy);
      cpsy = round_prod(cp, sy);
      spcy = round_prod(sp, cy);
      q.quat_w = quat_round(cr * cpcy + sr * spsy);
      q.quat_x = quat_round(sr * cpcy - cr * spsy);
      q.quat_y = quat_round(cr * spcy + sr * cpsy);
      q.quat_z = quat_round(cr * cpsy - sr * spcy);
      return q;
   endfunction

   // receiver stall pattern: random with calm stretches, forced on, or forced off
   always @(posedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else if (!rx_random) rsp_ready <= 1'b1;
      else rsp_ready <= (cycle_count % 200 < 60) ? 1'b1 : ($urandom_range(3, 0) != 0);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (quat_queue.size() == 0) begin
            $display("%0t unexpected result: actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = quat_queue.pop_front();
            if (rsp_data.quat_w !== want.quat_w)
               $display("%0t quat_w expected %0d actual %0d", $time,
                        want.quat_w, rsp_data.quat_w);
            if (rsp_data.quat_x !== want.quat_x)
               $display("%0t quat_x expected %0d actual %0d", $time,
                        want.quat_x, rsp_data.quat_x);
            if (rsp_data.quat_y !== want.quat_y)
               $display("%0t quat_y expected %0d actual %0d", $time,
                        want.quat_y, rsp_data.quat_y);
            if (rsp_data.quat_z !== want.quat_z)
               $display("%0t quat_z expected %0d actual %0d", $time,
                        want.quat_z, rsp_data.quat_z);
            if (rsp_data !== want) fail_count++;
         end
      end
   end

   // offer one item; valid stays up if another follows with no gap,
   // otherwise it drops, leaving a gap before the next item
   task automatic send_angles(input req_type a, input bit keep);
      req_valid <= 1'b1;
      req_data <= a;
      do @(posedge clock); while (!req_ready);
      quat_queue.insert(quat_queue.size(), predict_quat(a));
      if (!keep) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic req_type rand_angles();
      req_type a;
      a = req_type'(48'({$urandom, $urandom}));
      return a;
   endfunction

   task automatic drain_results();
      while (quat_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic signed [15:0] corner[10] = '{16'sh8000, 16'sh7fff, 16'sh0000,
         16'shffff, 16'sh0001, 16'sd6434, -16'sd6434, 16'sd6433, 16'sd12868,
         -16'sd12868};
      req_type a;
      for (int i = 0; i < 10; i++) begin
         a = '{corner[i], corner[(i + 3) % 10], corner[(i + 7) % 10]};
         send_angles(a, 1'b0);
      end
      for (int i = 0; i < 10; i++) begin
         a = '{corner[i], corner[i], corner[i]};
         send_angles(a, i != 9);
      end
   endtask

   task automatic test_random(input int count);
      int burst;
      int n;
      n = 0;
      while (n < count) begin
         burst = $urandom_range(40, 1);
         for (int i = 0; i < burst && n < count; i++, n++)
            send_angles(rand_angles(), i != burst - 1 && n != count - 1);
         repeat ($urandom_range(6, 0)) @(posedge clock);
      end
   endtask

   // receiver stalls long while the sender keeps offering: fills the pipe
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (150) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 80; i++) send_angles(rand_angles(), i != 79);
      join
      drain_results();
   endtask

   task automatic test_full_rate();
      rx_random = 1'b0;
      for (int i = 0; i < 200; i++) send_angles(rand_angles(), i != 199);
      drain_results();
      rx_random = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain_results();
      test_random(800);
      test_backpressure();
      test_full_rate();
      test_random(850);
      drain_results();
      repeat (Latency + 10) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

[files.f]
rtl/core/etq_pkg.sv
rtl/core/etq_front.sv
rtl/core/etq_queue.sv
rtl/core/etq_back.sv
rtl/core/euler_to_quaternion.sv
dv/euler_to_quaternion_tb.sv
